[rtl/ihc_pkg.sv]
// Shared types and constants for the IPv4 header checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package ihc_pkg;

  localparam int unsigned MIN_HEADER_BYTES = 20;
  localparam logic [3:0]  IP_VERSION       = 4'd4;
  localparam logic [3:0]  IHL_MASK         = 4'hF;
  localparam logic [15:0] COUNT_MAX        = 16'hFFFF;
  localparam logic [15:0] SUM_GOOD         = 16'hFFFF;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [15:0] IDX_VER_IHL  = 16'd0;
  localparam logic [15:0] IDX_LEN_HI   = 16'd2;
  localparam logic [15:0] IDX_LEN_LO   = 16'd3;
  localparam logic [15:0] IDX_PROTO    = 16'd9;
  localparam logic [15:0] IDX_DST_FIRST = 16'd16;
  localparam logic [15:0] IDX_DST_LAST  = 16'd19;

  localparam logic [2:0] ST_ACCEPTED   = 3'd0;
  localparam logic [2:0] ST_TOO_SHORT  = 3'd1;
  localparam logic [2:0] ST_BAD_VER    = 3'd2;
  localparam logic [2:0] ST_INCOMPLETE = 3'd3;
  localparam logic [2:0] ST_BAD_CSUM   = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;
  localparam logic [2:0] ST_NOT_OURS   = 3'd6;

  localparam logic [1:0] CLS_ICMP  = 2'd0;
  localparam logic [1:0] CLS_TCP   = 2'd1;
  localparam logic [1:0] CLS_UDP   = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [15:0] sum;
    logic [7:0]  version_and_ihl;
    logic [15:0] ip_len;
    logic [7:0]  protocol;
    logic [31:0] destination;
  } hdr_info_t;

  function automatic logic [5:0] header_bytes(input logic [7:0] vih);
    header_bytes = {vih[3:0] & IHL_MASK, 2'b00};
  endfunction

endpackage

`default_nettype wire

[rtl/ihc_parser.sv]
// Input register and per-packet header state: byte count, checksum, fields.
// Depends on ihc_pkg.
`default_nettype none

module ihc_parser
  import ihc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] byte_value,
  input  wire logic       last_byte,
  input  wire logic       out_free,
  output logic            done,
  output hdr_info_t       info
);

  logic        s1_valid;
  logic [7:0]  s1_byte;
  logic        s1_last;
  logic        advance;

  logic [15:0] byte_count;
  logic [15:0] sum;
  logic [7:0]  pending_high;
  logic [7:0]  version_and_ihl;
  logic [15:0] ip_len;
  logic [7:0]  protocol;
  logic [31:0] destination;

  logic [15:0] byte_count_next;
  logic [15:0] sum_next;
  logic [7:0]  pending_high_next;
  logic [7:0]  version_and_ihl_next;
  logic [15:0] ip_len_next;
  logic [7:0]  protocol_next;
  logic [31:0] destination_next;
  logic [5:0]  hdr_len;
  logic        in_header;
  logic [16:0] raw_sum;

  assign advance  = s1_valid && (!s1_last || out_free);
  assign in_ready = !s1_valid || advance;
  assign done     = advance && s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte <= byte_value;
      s1_last <= last_byte;
    end
  end

  always_comb begin
    version_and_ihl_next = (byte_count == IDX_VER_IHL) ? s1_byte : version_and_ihl;
    ip_len_next          = ip_len;
    if (byte_count == IDX_LEN_HI) begin
      ip_len_next = {s1_byte, ip_len[7:0]};
    end else if (byte_count == IDX_LEN_LO) begin
      ip_len_next = {ip_len[15:8], s1_byte};
    end
    protocol_next = (byte_count == IDX_PROTO) ? s1_byte : protocol;
    destination_next = destination;
    if (byte_count >= IDX_DST_FIRST && byte_count <= IDX_DST_LAST) begin
      destination_next = {destination[23:0], s1_byte};
    end

    hdr_len   = header_bytes(version_and_ihl_next);
    in_header = (byte_count != COUNT_MAX) && (byte_count < {10'd0, hdr_len});
    raw_sum   = {1'b0, sum} + {1'b0, pending_high, s1_byte};
    pending_high_next = pending_high;
    sum_next          = sum;
    if (in_header) begin
      if (!byte_count[0]) begin
        pending_high_next = s1_byte;
      end else begin
        sum_next = raw_sum[15:0] + {15'd0, raw_sum[16]};
      end
    end

    byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 16'd1;
  end

  always_comb begin
    info.byte_count      = byte_count_next;
    info.sum             = sum_next;
    info.version_and_ihl = version_and_ihl_next;
    info.ip_len          = ip_len_next;
    info.protocol        = protocol_next;
    info.destination     = destination_next;
  end

  always_ff @(posedge clk) begin
    if (rst || done) begin
      byte_count      <= '0;
      sum             <= '0;
      pending_high    <= '0;
      version_and_ihl <= '0;
      ip_len          <= '0;
      protocol        <= '0;
      destination     <= '0;
    end else if (advance) begin
      byte_count      <= byte_count_next;
      sum             <= sum_next;
      pending_high    <= pending_high_next;
      version_and_ihl <= version_and_ihl_next;
      ip_len          <= ip_len_next;
      protocol        <= protocol_next;
      destination     <= destination_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ihc_verdict.sv]
// Verdict logic and result register: status, protocol class, payload length.
// Depends on ihc_pkg.
`default_nettype none

module ihc_verdict
  import ihc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        done,
  input  wire hdr_info_t   info,
  input  wire logic [31:0] local_address,
  output logic             out_free,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [1:0]       protocol_class,
  output logic [7:0]       protocol_number,
  output logic [15:0]      payload_length
);

  logic [5:0]  hdr_len;
  logic [15:0] hdr_len_w;
  logic [2:0]  status_next;
  logic [1:0]  class_next;
  logic [15:0] payload_next;

  assign out_free = !out_valid || out_ready;

  always_comb begin
    hdr_len   = header_bytes(info.version_and_ihl);
    hdr_len_w = {10'd0, hdr_len};

    if (info.byte_count < 16'(MIN_HEADER_BYTES)) begin
      status_next = ST_TOO_SHORT;
    end else if (info.version_and_ihl[7:4] != IP_VERSION) begin
      status_next = ST_BAD_VER;
    end else if (info.byte_count < hdr_len_w) begin
      status_next = ST_INCOMPLETE;
    end else if (info.sum != SUM_GOOD) begin
      status_next = ST_BAD_CSUM;
    end else if (info.byte_count < info.ip_len) begin
      status_next = ST_TRUNCATED;
    end else if (info.destination != local_address) begin
      status_next = ST_NOT_OURS;
    end else begin
      status_next = ST_ACCEPTED;
    end

    case (info.protocol)
      PROTO_ICMP: class_next = CLS_ICMP;
      PROTO_TCP:  class_next = CLS_TCP;
      PROTO_UDP:  class_next = CLS_UDP;
      default:    class_next = CLS_OTHER;
    endcase

    payload_next = (info.ip_len > hdr_len_w) ? info.ip_len - hdr_len_w : 16'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      status          <= status_next;
      protocol_class  <= class_next;
      protocol_number <= info.protocol;
      payload_length  <= payload_next;
    end
  end

endmodule

`default_nettype wire

[rtl/ipv4_header_checker_unit.sv]
// Top level of the IPv4 receive header checker.
// Depends on ihc_pkg, ihc_parser and ihc_verdict.
//
//   channel  direction  handshake            payload
//   in       input      in_valid/in_ready    byte_value, last_byte
//   out      output     out_valid/out_ready  status, protocol_class,
//                                            protocol_number, payload_length
//   cfg      input      cfg_valid/cfg_ready  local_address
//
// One byte per cycle unless a stalled verdict holds a last byte; out_valid rises
// once the last byte has passed the input register and then the result register.
// Reset clears the packet state, local_address and both valid flags.
// A stalled verdict holds the input register only while it carries a last
// byte; other bytes keep flowing. cfg_ready is always high.
`default_nettype none

module ipv4_header_checker_unit
  import ihc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [1:0]       protocol_class,
  output logic [7:0]       protocol_number,
  output logic [15:0]      payload_length,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] local_address
);

  logic        done;
  logic        out_free;
  hdr_info_t   info;
  logic [31:0] local_addr;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      local_addr <= '0;
    end else if (cfg_valid && cfg_ready) begin
      local_addr <= local_address;
    end
  end

  ihc_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .byte_value (byte_value),
    .last_byte  (last_byte),
    .out_free   (out_free),
    .done       (done),
    .info       (info)
  );

  ihc_verdict u_verdict (
    .clk             (clk),
    .rst             (rst),
    .done            (done),
    .info            (info),
    .local_address   (local_addr),
    .out_free        (out_free),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .protocol_class  (protocol_class),
    .protocol_number (protocol_number),
    .payload_length  (payload_length)
  );

endmodule

`default_nettype wire

[rtl/ihc_checker.sv]
// Port-level checks for ipv4_header_checker_unit, attached by bind.
// Depends on ihc_pkg.
`default_nettype none

module ihc_checker
  import ihc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  status,
  input wire logic [1:0]  protocol_class,
  input wire logic [7:0]  protocol_number,
  input wire logic [15:0] payload_length
);

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(protocol_class)
      && $stable(protocol_number) && $stable(payload_length))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= ST_NOT_OURS)
    else $error("status code out of range");

  a_class_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((protocol_number == PROTO_ICMP) == (protocol_class == CLS_ICMP))
      && ((protocol_number == PROTO_TCP) == (protocol_class == CLS_TCP))
      && ((protocol_number == PROTO_UDP) == (protocol_class == CLS_UDP)))
    else $error("protocol class does not match protocol number");

endmodule

bind ipv4_header_checker_unit ihc_checker u_ihc_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .status          (status),
  .protocol_class  (protocol_class),
  .protocol_number (protocol_number),
  .payload_length  (payload_length)
);

`default_nettype wire
